@@ src/bdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdt_pkg - double-tap detector shared definitions
// Types, phase codes and the saturating timer step used by the detector.
// ----------------------------------------------------------------------------
package bdt_pkg;

    localparam int MASK_W  = 32;
    localparam int TIME_W  = 16;
    localparam int CNT_W   = 25;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 2;

    // phase codes
    localparam logic [PHASE_W-1:0] PHASE_IDLE     = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_FIRST    = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_RELEASED = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_TAP      = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_MARGIN = 2'd2;

    localparam logic [TIME_W-1:0] WINDOW_TIME_RST  = 16'd1024;
    localparam logic [TIME_W-1:0] HOLD_TIME_RST    = 16'd341;
    localparam logic [TIME_W-1:0] CLEAR_MARGIN_RST = 16'd8192;

    // timer floor, -2^24
    localparam logic signed [CNT_W:0]   CNT_FLOOR_WIDE = -26'sd16777216;
    localparam logic signed [CNT_W-1:0] CNT_FLOOR      = -25'sd16777216;

    typedef struct packed {
        logic [MASK_W-1:0] held_buttons;
        logic [MASK_W-1:0] pressed_buttons;
        logic [TIME_W-1:0] elapsed;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] window_time;
        logic [TIME_W-1:0] hold_time;
        logic [TIME_W-1:0] clear_margin;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0]      phase;
        logic signed [CNT_W-1:0] countdown;
        logic [MASK_W-1:0]       first_mask;
        logic [MASK_W-1:0]       report_mask;
        logic [MASK_W-1:0]       latch_mask;
    } state_t;

    // timer decrement, saturating at the floor
    function automatic logic signed [CNT_W-1:0] tick_down(
        input logic signed [CNT_W-1:0] t,
        input logic [TIME_W-1:0]       dt
    );
        logic signed [CNT_W:0] v;
        begin
            v = $signed({t[CNT_W-1], t}) - $signed({{(CNT_W+1-TIME_W){1'b0}}, dt});
            if (v < CNT_FLOOR_WIDE)
            begin
                tick_down = CNT_FLOOR;
            end
            else
            begin
                tick_down = v[CNT_W-1:0];
            end
        end
    endfunction

endpackage

@@ src/button_double_tap_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_double_tap_detector - double-tap detector for a button mask
// Per-frame phase machine: press, release, same mask again within the window.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------
//  in      | input     | in_valid/in_stall | held_buttons, pressed_buttons, elapsed
//  out     | output    | out_valid/out_stall | tap_mask, latched_mask, phase
//  cfg     | input     | cfg_write         | cfg_index, cfg_data
//
//  One frame per clock sustained while out_stall stays low. A frame lands in the
//  input register on its transfer; once the result slot is free, the phase
//  machine update writes state and the result register together, so a result
//  passes the input register and then the result register before its transfer.
//  The state feedback is a single compare/subtract step, which sets the rate.
//  Reset clears the detector state and both valid flags and loads the register defaults.
//  A stalled result holds; the input register still takes one more frame, and
//  in_stall rises only when both stages are full.
//
module button_double_tap_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bdt_pkg::MASK_W-1:0]          held_buttons,
    input  logic [bdt_pkg::MASK_W-1:0]          pressed_buttons,
    input  logic [bdt_pkg::TIME_W-1:0]          elapsed,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bdt_pkg::MASK_W-1:0]          tap_mask,
    output logic [bdt_pkg::MASK_W-1:0]          latched_mask,
    output logic [bdt_pkg::PHASE_W-1:0]         phase,
    // configuration
    input  logic                                cfg_write,
    input  logic [bdt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bdt_pkg::TIME_W-1:0]          cfg_data
);

    bdt_pkg::item_t  in_item;
    bdt_pkg::item_t  item;
    logic            item_valid;
    logic            advance;

    bdt_pkg::cfg_t   cfg_reg;
    bdt_pkg::cfg_t   cfg_next;
    bdt_pkg::state_t state_reg;
    bdt_pkg::state_t state_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [bdt_pkg::MASK_W-1:0]  tap_mask_reg;
    logic [bdt_pkg::MASK_W-1:0]  latched_mask_reg;
    logic [bdt_pkg::PHASE_W-1:0] phase_out_reg;

    assign in_item.held_buttons    = held_buttons;
    assign in_item.pressed_buttons = pressed_buttons;
    assign in_item.elapsed         = elapsed;

    // the update stage moves when a frame waits and the result slot is free
    assign advance = item_valid && (!out_valid_reg || !out_stall);

    bdt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bdt_update u_update (
        .item (item),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // configuration registers; writes to unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                bdt_pkg::REG_WINDOW_TIME:  cfg_next.window_time  = cfg_data;
                bdt_pkg::REG_HOLD_TIME:    cfg_next.hold_time    = cfg_data;
                bdt_pkg::REG_CLEAR_MARGIN: cfg_next.clear_margin = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_time  <= bdt_pkg::WINDOW_TIME_RST;
            cfg_reg.hold_time    <= bdt_pkg::HOLD_TIME_RST;
            cfg_reg.clear_margin <= bdt_pkg::CLEAR_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // detector state advances once per frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tap_mask_reg     <= state_next.report_mask;
            latched_mask_reg <= state_next.latch_mask;
            phase_out_reg    <= state_next.phase;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tap_mask     = tap_mask_reg;
    assign latched_mask = latched_mask_reg;
    assign phase        = phase_out_reg;

`ifndef ASSERT_OFF
    // state moves only together with a new result
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("detector state changed without a frame update");

    // a shown result always matches the live phase
    a_phase_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (phase == state_reg.phase))
        else $error("result phase differs from detector phase");

    // timer never exceeds a 16-bit reload
    a_timer_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.countdown <= $signed(25'd65535))
        else $error("timer above its largest reload");

    // input stalls only with a frame already waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");
`endif

endmodule

@@ src/bdt_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdt_in_stage - input register
// Captures one frame per transfer; holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module bdt_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bdt_pkg::item_t in_item,
    input  logic          advance,
    output logic          item_valid,
    output bdt_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    bdt_pkg::item_t item_reg;
    logic           load;

    assign in_stall   = valid_reg && !advance;
    assign load       = !in_stall;
    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ src/bdt_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdt_update - next-state logic
// One frame's step of the four-phase double-tap machine.
// ----------------------------------------------------------------------------
module bdt_update (
    input  bdt_pkg::item_t  item,
    input  bdt_pkg::cfg_t   cfg,
    input  bdt_pkg::state_t cur,
    output bdt_pkg::state_t nxt
);

    logic [bdt_pkg::MASK_W-1:0]      act;
    logic signed [bdt_pkg::CNT_W-1:0] ticked;
    logic signed [bdt_pkg::TIME_W:0]  limit;
    logic signed [bdt_pkg::CNT_W-1:0] limit_ext;
    logic [bdt_pkg::PHASE_W-1:0]     ph;
    logic                            ticked_le0;

    assign act        = item.held_buttons & item.pressed_buttons;
    assign ticked     = bdt_pkg::tick_down(cur.countdown, item.elapsed);
    assign ticked_le0 = ticked[bdt_pkg::CNT_W-1] || (ticked == '0);
    assign limit      = $signed({1'b0, cfg.hold_time}) - $signed({1'b0, cfg.clear_margin});
    assign limit_ext  = $signed({{(bdt_pkg::CNT_W-bdt_pkg::TIME_W-1){limit[bdt_pkg::TIME_W]}},
                                 limit});

    always_comb
    begin
        nxt = cur;
        ph  = cur.phase;
        // latch release: pressed set dropped away
        if ((cur.latch_mask != '0) && (act == '0))
        begin
            nxt.latch_mask = '0;
            ph             = bdt_pkg::PHASE_IDLE;
        end
        nxt.phase = ph;
        unique case (ph)
            bdt_pkg::PHASE_IDLE:
            begin
                if (act != '0)
                begin
                    nxt.first_mask = act;
                    nxt.countdown  = $signed({{(bdt_pkg::CNT_W-bdt_pkg::TIME_W){1'b0}},
                                              cfg.window_time});
                    nxt.phase      = bdt_pkg::PHASE_FIRST;
                end
            end
            bdt_pkg::PHASE_FIRST:
            begin
                nxt.countdown = ticked;
                if (ticked_le0)
                begin
                    nxt.phase = bdt_pkg::PHASE_IDLE;
                end
                else if (act == '0)
                begin
                    nxt.phase = bdt_pkg::PHASE_RELEASED;
                end
            end
            bdt_pkg::PHASE_RELEASED:
            begin
                nxt.countdown = ticked;
                if (ticked_le0)
                begin
                    nxt.phase = bdt_pkg::PHASE_IDLE;
                end
                else if (cur.first_mask == act)
                begin
                    nxt.phase       = bdt_pkg::PHASE_TAP;
                    nxt.countdown   = $signed({{(bdt_pkg::CNT_W-bdt_pkg::TIME_W){1'b0}},
                                               cfg.hold_time});
                    nxt.latch_mask  = cur.first_mask;
                    nxt.report_mask = cur.first_mask;
                end
            end
            default:
            begin
                // report clear uses the timer before this frame's decrement
                if (cur.countdown < limit_ext)
                begin
                    nxt.report_mask = '0;
                end
                if (cur.first_mask != act)
                begin
                    nxt.phase = bdt_pkg::PHASE_IDLE;
                end
                else
                begin
                    nxt.countdown = ticked;
                    if (ticked == '0)
                    begin
                        nxt.latch_mask = cur.first_mask
                                       | (item.held_buttons & ~item.pressed_buttons);
                    end
                end
            end
        endcase
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the button double-tap detector
// Drives frames through the valid/stall input channel and checks every result
// transfer against an in-bench model of the phase machine. A short directed
// table opens the run. Random phases under several register settings follow,
// with idle cycles and output stalls at random on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic [bdt_pkg::MASK_W-1:0]        mask_t;
    typedef logic [bdt_pkg::TIME_W-1:0]        dt_t;
    typedef logic signed [bdt_pkg::CNT_W-1:0]  count_t;

    // one result transfer: what the detector reports after a frame
    typedef struct packed {
        mask_t                       tap_mask;
        mask_t                       latched_mask;
        logic [bdt_pkg::PHASE_W-1:0] phase;
    } tap_report_t;

    // directed row: a frame and, where it is obvious, the report it must give
    typedef struct packed {
        bdt_pkg::item_t frame;
        logic           has_want;
        tap_report_t    want;
    } tap_row_t;

    localparam int TIMER_FLOOR = -(1 << 24);
    localparam int N_DIRECTED  = 24;

    // Directed frames, run with the reset register values
    // (window 1024, hold 341, margin 8192).
    localparam tap_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        // nothing pressed right after reset
        '{'{32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{32'h0000_0000, 32'h0000_0000, bdt_pkg::PHASE_IDLE}},
        // all buttons, max elapsed: first press
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
          '{32'h0000_0000, 32'h0000_0000, bdt_pkg::PHASE_FIRST}},
        // release inside the window
        '{'{32'h0000_0000, 32'h0000_0000, 16'h0001}, 1'b1,
          '{32'h0000_0000, 32'h0000_0000, bdt_pkg::PHASE_RELEASED}},
        // same mask again: double tap, report and latch set
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001}, 1'b1,
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, bdt_pkg::PHASE_TAP}},
        // latch release: no active press drops the latch and goes idle
        '{'{32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b1,
          '{32'hFFFF_FFFF, 32'h0000_0000, bdt_pkg::PHASE_IDLE}},
        // single bit tap, timer run down to exactly zero in the held phase
        '{'{32'h0000_0001, 32'h0000_0001, 16'h0000}, 1'b0, '0},
        '{'{32'h0000_0000, 32'h0000_0000, 16'h03FF}, 1'b0, '0},
        '{'{32'h8000_0001, 32'h0000_0001, 16'h0000}, 1'b0, '0},
        '{'{32'h8000_0001, 32'h0000_0001, 16'h0155}, 1'b0, '0},
        // timer well below the clear limit: report cleared on the next frame
        '{'{32'h0000_0001, 32'h0000_0001, 16'hFFFF}, 1'b0, '0},
        '{'{32'h0000_0001, 32'h0000_0001, 16'hFFFF}, 1'b0, '0},
        // mask change during the double tap keeps latch and report
        '{'{32'h0000_0003, 32'h0000_0003, 16'h0000}, 1'b0, '0},
        '{'{32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '0},
        // window runs out exactly while still held
        '{'{32'h0000_0004, 32'h0000_0004, 16'h0000}, 1'b0, '0},
        '{'{32'h0000_0004, 32'h0000_0004, 16'h0400}, 1'b0, '0},
        // window runs out exactly while released
        '{'{32'h0000_0008, 32'h0000_000C, 16'h0000}, 1'b0, '0},
        '{'{32'h0000_000F, 32'h0000_0000, 16'h0005}, 1'b0, '0},
        '{'{32'h0000_0008, 32'h0000_0008, 16'h03FB}, 1'b0, '0},
        // wrong mask on the second press is ignored, the right one taps
        '{'{32'h0000_0010, 32'h0000_0010, 16'h0000}, 1'b0, '0},
        '{'{32'h0000_0000, 32'h0000_0000, 16'h0000}, 1'b0, '0},
        '{'{32'h0000_0020, 32'h0000_0020, 16'h0000}, 1'b0, '0},
        '{'{32'h0000_0010, 32'h0000_0010, 16'h0000}, 1'b0, '0},
        // latch picks up held-not-pressed buttons at timer zero
        '{'{32'hFFFF_FFFF, 32'h0000_0010, 16'h0155}, 1'b0, '0},
        // pressed without held is no active press
        '{'{32'h0000_0000, 32'hFFFF_FFFF, 16'h0000}, 1'b0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                        in_valid        = 1'b0;
    logic                        in_stall;
    mask_t                       held_buttons    = '0;
    mask_t                       pressed_buttons = '0;
    dt_t                         elapsed         = '0;

    logic                        out_valid;
    logic                        out_stall       = 1'b0;
    mask_t                       tap_mask;
    mask_t                       latched_mask;
    logic [bdt_pkg::PHASE_W-1:0] phase;

    logic                          cfg_write = 1'b0;
    logic [bdt_pkg::CFG_IDX_W-1:0] cfg_index = bdt_pkg::REG_WINDOW_TIME;
    dt_t                           cfg_data  = '0;

    // model copy of the registers
    dt_t cfg_window = bdt_pkg::WINDOW_TIME_RST;
    dt_t cfg_hold   = bdt_pkg::HOLD_TIME_RST;
    dt_t cfg_margin = bdt_pkg::CLEAR_MARGIN_RST;

    // model copy of the detector state
    logic [bdt_pkg::PHASE_W-1:0] st_phase  = bdt_pkg::PHASE_IDLE;
    count_t                      st_count  = '0;
    mask_t                       st_first  = '0;
    mask_t                       st_report = '0;
    mask_t                       st_latch  = '0;

    tap_report_t tap_reports_due [$];
    int          mismatch_count = 0;
    int          frames_sent    = 0;
    bit          calm           = 1'b0;  // no idling on either side when set

    button_double_tap_detector u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .held_buttons    (held_buttons),
        .pressed_buttons (pressed_buttons),
        .elapsed         (elapsed),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tap_mask        (tap_mask),
        .latched_mask    (latched_mask),
        .phase           (phase),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model of the phase machine
    // ------------------------------------------------------------------------

    // timer step with saturation at the floor
    function automatic count_t drain_timer(
        input count_t t,
        input dt_t    dt
    );
        int v;
        v = int'(t) - int'(dt);
        if (v < TIMER_FLOOR)
        begin
            v = TIMER_FLOOR;
        end
        return count_t'(v);
    endfunction

    // advance the model by one frame and return the report it gives
    function automatic tap_report_t advance_detector(input bdt_pkg::item_t f);
        mask_t       act;
        int          limit;
        tap_report_t r;
        act = f.held_buttons & f.pressed_buttons;

        // latch release runs ahead of the phase logic
        if (st_latch != '0 && act == '0)
        begin
            st_latch = '0;
            st_phase = bdt_pkg::PHASE_IDLE;
        end

        case (st_phase)
            bdt_pkg::PHASE_IDLE:
            begin
                if (act != '0)
                begin
                    st_first = act;
                    st_count = {{(bdt_pkg::CNT_W-bdt_pkg::TIME_W){1'b0}}, cfg_window};
                    st_phase = bdt_pkg::PHASE_FIRST;
                end
            end
            bdt_pkg::PHASE_FIRST:
            begin
                st_count = drain_timer(st_count, f.elapsed);
                if (st_count <= 0)
                begin
                    st_phase = bdt_pkg::PHASE_IDLE;
                end
                else if (act == '0)
                begin
                    st_phase = bdt_pkg::PHASE_RELEASED;
                end
            end
            bdt_pkg::PHASE_RELEASED:
            begin
                st_count = drain_timer(st_count, f.elapsed);
                if (st_count <= 0)
                begin
                    st_phase = bdt_pkg::PHASE_IDLE;
                end
                else if (st_first == act)
                begin
                    st_phase  = bdt_pkg::PHASE_TAP;
                    st_count  = {{(bdt_pkg::CNT_W-bdt_pkg::TIME_W){1'b0}}, cfg_hold};
                    st_latch  = st_first;
                    st_report = st_first;
                end
            end
            default:
            begin
                // clear test uses the timer before this frame's decrement
                limit = int'(cfg_hold) - int'(cfg_margin);
                if (int'(st_count) < limit)
                begin
                    st_report = '0;
                end
                if (st_first != act)
                begin
                    st_phase = bdt_pkg::PHASE_IDLE;
                end
                else
                begin
                    st_count = drain_timer(st_count, f.elapsed);
                    if (st_count == 0)
                    begin
                        st_latch = st_first | (f.held_buttons & ~f.pressed_buttons);
                    end
                end
            end
        endcase

        r.tap_mask     = st_report;
        r.latched_mask = st_latch;
        r.phase        = st_phase;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Frame builders for the random part
    // ------------------------------------------------------------------------

    // frame whose active press is exactly mask, with random extra bits that
    // are held or pressed but never both
    function automatic bdt_pkg::item_t press_of(input mask_t mask,
                                                input dt_t   dt);
        mask_t          h_extra;
        mask_t          p_extra;
        bdt_pkg::item_t f;
        h_extra = ($urandom_range(0, 1) != 0) ? ($urandom() & $urandom()) : '0;
        p_extra = $urandom() & $urandom() & ~(mask | h_extra);
        f.held_buttons    = mask | h_extra;
        f.pressed_buttons = mask | p_extra;
        f.elapsed         = dt;
        return f;
    endfunction

    // frame with no active press
    function automatic bdt_pkg::item_t release_of(input dt_t dt);
        bdt_pkg::item_t f;
        f.held_buttons    = $urandom();
        f.pressed_buttons = $urandom() & ~f.held_buttons;
        f.elapsed         = dt;
        return f;
    endfunction

    function automatic mask_t pick_mask();
        case ($urandom_range(0, 3))
            0:       return mask_t'(1) << $urandom_range(0, bdt_pkg::MASK_W - 1);
            1:       return $urandom()
                            | (mask_t'(1) << $urandom_range(0, bdt_pkg::MASK_W - 1));
            2:       return '1;
            default: return mask_t'($urandom_range(1, 15));
        endcase
    endfunction

    // frame time that keeps a tap sequence inside the window
    function automatic dt_t short_dt();
        return dt_t'($urandom_range(0, int'(cfg_window) / 8));
    endfunction

    // frame time while the tap is held: hit zero exactly, stay small,
    // or jump far enough to clear the report
    function automatic dt_t hold_dt();
        case ($urandom_range(0, 3))
            0:
            begin
                if (st_phase == bdt_pkg::PHASE_TAP && st_count >= 0 && st_count <= 65535)
                begin
                    return dt_t'(st_count);
                end
                return dt_t'($urandom());
            end
            1:       return dt_t'($urandom_range(0, 64));
            2:       return dt_t'($urandom());
            default: return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input channel driver
    // ------------------------------------------------------------------------

    // Present one frame and hold it until its transfer. The model runs at the
    // transfer edge; a typed expectation, where given, replaces its report.
    task automatic send_frame(input bdt_pkg::item_t f, input bit has_want = 1'b0,
                              input tap_report_t want = '0);
        tap_report_t got;
        while (!calm && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        held_buttons    <= f.held_buttons;
        pressed_buttons <= f.pressed_buttons;
        elapsed         <= f.elapsed;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        frames_sent++;
        got = advance_detector(f);
        tap_reports_due.push_back(has_want ? want : got);
    endtask

    // press, release, press again, hold, then let go or change the mask
    task automatic play_double_tap(input bit long_hold);
        mask_t mask;
        mask_t second;
        mask = pick_mask();
        send_frame(press_of(mask, short_dt()));
        repeat ($urandom_range(0, 2)) send_frame(press_of(mask, short_dt()));
        repeat ($urandom_range(1, 3)) send_frame(release_of(short_dt()));
        second = ($urandom_range(0, 9) == 0) ? pick_mask() : mask;
        send_frame(press_of(second, short_dt()));
        if (long_hold)
        begin
            // enough max-size steps to pin the timer at its floor
            repeat (300) send_frame(press_of(mask, '1));
        end
        else
        begin
            repeat ($urandom_range(0, 8)) send_frame(press_of(mask, hold_dt()));
        end
        if ($urandom_range(0, 3) != 0)
        begin
            send_frame(release_of(short_dt()));
        end
        else
        begin
            send_frame(press_of(pick_mask(), hold_dt()));
        end
    endtask

    // drain outstanding results; the block has no result-less frames, so a
    // short pause after the last transfer is enough
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tap_reports_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bdt_pkg::CFG_IDX_W-1:0] idx,
                             input dt_t value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            bdt_pkg::REG_WINDOW_TIME: cfg_window = value;
            bdt_pkg::REG_HOLD_TIME:   cfg_hold   = value;
            default:                  cfg_margin = value;
        endcase
    endtask

    // one random phase under one register setting
    task automatic run_phase(input dt_t window,
                             input dt_t hold,
                             input dt_t margin,
                             input int count, input bit with_floor,
                             input bit no_idle);
        int target;
        int kind;
        wait_drained();
        write_reg(bdt_pkg::REG_WINDOW_TIME, window);
        write_reg(bdt_pkg::REG_HOLD_TIME, hold);
        write_reg(bdt_pkg::REG_CLEAR_MARGIN, margin);
        cfg_write <= 1'b0;
        @(posedge clk);
        calm   = no_idle;
        target = frames_sent + count;
        if (with_floor)
        begin
            play_double_tap(1'b1);
        end
        while (frames_sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                play_double_tap(1'b0);
            end
            else if (kind < 80)
            begin
                // broken sequence: a press left to time out or answered late
                send_frame(press_of(pick_mask(), short_dt()));
                send_frame(release_of(dt_t'($urandom())));
                send_frame(press_of(pick_mask(), dt_t'($urandom())));
            end
            else
            begin
                send_frame('{$urandom(), $urandom(), dt_t'($urandom())});
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall and result check
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 32);
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        tap_report_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (tap_reports_due.size() == 0)
            begin
                $error("result transfer with nothing expected: %s %h %h phase %0d",
                       "tap_mask/latched_mask", tap_mask, latched_mask, phase);
                mismatch_count++;
            end
            else
            begin
                exp_r = tap_reports_due.pop_front();
                if (tap_mask !== exp_r.tap_mask)
                begin
                    $error("tap_mask: expected %h, got %h", exp_r.tap_mask, tap_mask);
                    mismatch_count++;
                end
                if (latched_mask !== exp_r.latched_mask)
                begin
                    $error("latched_mask: expected %h, got %h",
                           exp_r.latched_mask, latched_mask);
                    mismatch_count++;
                end
                if (phase !== exp_r.phase)
                begin
                    $error("phase: expected %0d, got %0d", exp_r.phase, phase);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset register values
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_frame(DIRECTED_ROWS[i].frame, DIRECTED_ROWS[i].has_want,
                       DIRECTED_ROWS[i].want);
        end

        // random phases: defaults, low extremes, high extremes, no idling,
        // then random settings
        run_phase(bdt_pkg::WINDOW_TIME_RST, bdt_pkg::HOLD_TIME_RST,
                  bdt_pkg::CLEAR_MARGIN_RST, 250, 1'b0, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 80, 1'b0, 1'b0);
        run_phase(16'd1, 16'd0, 16'd0, 150, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 350, 1'b1, 1'b0);
        run_phase(16'hFFFF, 16'd0, 16'd0, 150, 1'b0, 1'b1);
        run_phase(dt_t'($urandom_range(64, 4096)), dt_t'($urandom_range(0, 2048)),
                  dt_t'($urandom()), 180, 1'b0, 1'b0);
        run_phase(dt_t'($urandom()), dt_t'($urandom()), dt_t'($urandom()),
                  170, 1'b0, 1'b0);

        wait_drained();
        calm = 1'b0;
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
src/bdt_pkg.sv
src/bdt_in_stage.sv
src/bdt_update.sv
src/button_double_tap_detector.sv
dv/tb_top.sv
